>>> rtl/rhmm_pkg.sv
// Package with the item types, control struct and shared codes of the motor mixer.
package rhmm_pkg;

   // Default number of fraction bits in the ramp values.
   localparam int FRACTION_BITS_DEF = 8;

   // Fixed field widths.
   localparam int CMD_W  = 16;
   localparam int RAMP_W = 18;
   localparam int SUM_W  = 31;
   localparam int STEP_W = 15;
   localparam int TRIM_W = 9;

   // Drive kinds.
   localparam logic [1:0] KIND_DIFF  = 2'd0;
   localparam logic [1:0] KIND_OMNI  = 2'd1;
   localparam logic [1:0] KIND_MECAN = 2'd2;

   // Motor direction codes.
   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_DRIVE_KIND = 2'd0;
   localparam logic [1:0] CSR_SIDE_TRIM  = 2'd1;
   localparam logic [1:0] CSR_RAMP_STEP  = 2'd2;

   typedef struct packed {
      logic              mode;
      logic signed [15:0] strafe_cmd;
      logic signed [15:0] forward_cmd;
      logic signed [15:0] turn_cmd;
   } req_type;

   typedef struct packed {
      logic [7:0] motor1_duty;
      logic [1:0] motor1_dir;
      logic [7:0] motor2_duty;
      logic [1:0] motor2_dir;
      logic [7:0] motor3_duty;
      logic [1:0] motor3_dir;
      logic [7:0] motor4_duty;
      logic [1:0] motor4_dir;
   } rsp_type;

   // Commands from the controller to the datapath, one per step.
   typedef struct packed {
      logic capture;
      logic ramp;
      logic mix;
      logic scale;
      logic emit;
   } cmd_type;

endpackage

>>> rtl/rhmm_ctrl.sv
// Controller state machine that steps one item through the mixer datapath.
module rhmm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rhmm_pkg::cmd_type cmd
);
   import rhmm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_MIX,
      ST_SCALE,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RAMP;
            end
         end
         ST_RAMP: begin
            cmd.ramp = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/rhmm_datapath.sv
// Datapath of the motor mixer: registers, ramps, mixing, scaling and duty mapping.
module rhmm_datapath #(
   parameter int FRACTION_BITS = rhmm_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rhmm_pkg::cmd_type  cmd,
   input  rhmm_pkg::req_type  req_data,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_data,
   output rhmm_pkg::rsp_type  rsp_data
);
   import rhmm_pkg::*;

   localparam int CMD_FRAC = 14;
   localparam logic [1:0] DIV_ONE  = 2'd0;
   localparam logic [1:0] DIV_200  = 2'd1;
   localparam logic [1:0] DIV_1000 = 2'd2;

   // Clamp to plus or minus one and scale to percent with fraction bits.
   function automatic logic signed [23:0] target_of(input logic signed [15:0] c);
      logic signed [15:0] cc;
      logic [14:0]        m;
      logic [20:0]        p;
      logic [23:0]        t;
      if (c > 16'sd16384)       cc = 16'sd16384;
      else if (c < -16'sd16384) cc = -16'sd16384;
      else                      cc = c;
      m = (cc < 0) ? 15'(-cc) : 15'(cc);
      p = 21'(m) * 21'd100;
      t = 24'(p >> (CMD_FRAC - FRACTION_BITS));
      return (cc < 0) ? -$signed(t) : $signed(t);
   endfunction

   // One ramp step towards the target, saturated to the ramp width.
   function automatic logic signed [17:0] ramp_next(input logic signed [17:0] cur,
                                                     input logic signed [23:0] tgt,
                                                     input logic [14:0] step);
      logic signed [23:0] v;
      v = 24'(cur);
      if (v < tgt)      v = v + $signed({9'b0, step});
      else if (v > tgt) v = v - $signed({9'b0, step});
      if (v > 24'sd131071)       v = 24'sd131071;
      else if (v < -24'sd131072) v = -24'sd131072;
      return v[17:0];
   endfunction

   // Truncate toward zero to whole percent, divide by the lane's divisor and clamp; returns sign and magnitude.
   function automatic logic [7:0] scale_lane(input logic signed [30:0] s,
                                             input logic [1:0] div);
      logic [30:0] mag;
      logic [30:0] t;
      logic [16:0] tc;
      logic [34:0] prod;
      logic [30:0] q;
      mag  = (s < 0) ? 31'(-s) : 31'(s);
      t    = mag >> FRACTION_BITS;
      tc   = '0;
      prod = '0;
      case (div)
         DIV_200: begin
            tc   = (t > 31'd20200) ? 17'd20200 : t[16:0];
            prod = 35'(tc) * 35'd5243;
            q    = 31'(prod >> 20);
         end
         DIV_1000: begin
            tc   = (t > 31'd101000) ? 17'd101000 : t[16:0];
            prod = 35'(tc) * 35'd134218;
            q    = 31'(prod >> 27);
         end
         default: begin
            q = t;
         end
      endcase
      if (q > 31'd100) q = 31'd100;
      return {(s < 0), q[6:0]};
   endfunction

   // Duty |s|*255/100 by reciprocal multiplication, exact for 0 to 100.
   function automatic logic [7:0] duty_of(input logic [6:0] m);
      logic [28:0] p;
      p = 29'(m) * 29'd2673930;
      return p[27:20];
   endfunction

   function automatic logic [1:0] dir_of(input logic [6:0] m, input logic neg);
      if (m == 7'd0) return DIR_OFF;
      return neg ? DIR_REV : DIR_FWD;
   endfunction

   logic [1:0]               drive_kind_ff;
   logic signed [TRIM_W-1:0] side_trim_ff;
   logic [STEP_W-1:0]        ramp_step_ff;

   req_type                  req_ff;
   logic signed [RAMP_W-1:0] ramp_x_ff, ramp_y_ff, ramp_w_ff;
   logic signed [RAMP_W-1:0] ramp_x_in, ramp_y_in, ramp_w_in;
   logic                     stop_ff;
   logic signed [SUM_W-1:0]  sum_ff [4];
   logic signed [SUM_W-1:0]  sum_in [4];
   logic [6:0]               mag_ff [4];
   logic                     neg_ff [4];
   logic [7:0]               lane_res [4];
   logic [1:0]               lane_div [4];
   rsp_type                  rsp_ff, rsp_in;
   logic [8:0]               trim_abs;
   logic [7:0]               trim_d, lf, rf;
   logic signed [SUM_W-1:0]  xs, ys, ws;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_kind_ff <= KIND_DIFF;
         side_trim_ff  <= '0;
         ramp_step_ff  <= 15'd1280;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DRIVE_KIND: drive_kind_ff <= csr_data[1:0];
            CSR_SIDE_TRIM:  side_trim_ff  <= csr_data[8:0];
            CSR_RAMP_STEP:  ramp_step_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Ramp update; a stop clears the ramps, differential drive drops x.
   always_comb begin
      ramp_x_in = ramp_next(ramp_x_ff, target_of(req_ff.strafe_cmd), ramp_step_ff);
      ramp_y_in = ramp_next(ramp_y_ff, target_of(req_ff.forward_cmd), ramp_step_ff);
      ramp_w_in = ramp_next(ramp_w_ff, target_of(req_ff.turn_cmd), ramp_step_ff);
      if (drive_kind_ff == KIND_DIFF) ramp_x_in = '0;
      if (req_ff.mode) begin
         ramp_x_in = '0;
         ramp_y_in = '0;
         ramp_w_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_x_ff <= '0;
         ramp_y_ff <= '0;
         ramp_w_ff <= '0;
      end else if (cmd.ramp) begin
         ramp_x_ff <= ramp_x_in;
         ramp_y_ff <= ramp_y_in;
         ramp_w_ff <= ramp_w_in;
      end
   end

   // Side factors for differential drive.
   assign trim_abs = side_trim_ff[8] ? 9'(-side_trim_ff) : 9'(side_trim_ff);
   assign trim_d   = (trim_abs > 9'd200) ? 8'd200 : trim_abs[7:0];
   assign lf       = (!side_trim_ff[8] && side_trim_ff != '0) ? 8'(8'd200 - trim_d) : 8'd200;
   assign rf       = side_trim_ff[8] ? 8'(8'd200 - trim_d) : 8'd200;

   assign xs = SUM_W'(ramp_x_ff);
   assign ys = SUM_W'(ramp_y_ff);
   assign ws = SUM_W'(ramp_w_ff);

   // Mixing for the selected drive kind.
   always_comb begin
      for (int i = 0; i < 4; i++) sum_in[i] = '0;
      case (drive_kind_ff)
         KIND_DIFF: begin
            sum_in[0] = (ys - ws) * $signed({23'b0, lf});
            sum_in[1] = (ys + ws) * $signed({23'b0, rf});
            sum_in[2] = sum_in[0];
            sum_in[3] = sum_in[1];
         end
         KIND_OMNI: begin
            sum_in[0] = ys + ws;
            sum_in[1] = -31'sd500 * ys + 31'sd866 * xs + 31'sd1000 * ws;
            sum_in[2] = -31'sd500 * ys - 31'sd866 * xs + 31'sd1000 * ws;
         end
         KIND_MECAN: begin
            sum_in[0] = ys + xs + ws;
            sum_in[1] = ys - xs - ws;
            sum_in[2] = ys - xs + ws;
            sum_in[3] = ys + xs - ws;
         end
         default: begin
         end
      endcase
   end

   // Divisor class and scaled result of each lane.
   always_comb begin
      for (int i = 0; i < 4; i++) lane_div[i] = DIV_ONE;
      case (drive_kind_ff)
         KIND_DIFF: begin
            for (int i = 0; i < 4; i++) lane_div[i] = DIV_200;
         end
         KIND_OMNI: begin
            lane_div[1] = DIV_1000;
            lane_div[2] = DIV_1000;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) lane_res[i] = scale_lane(sum_ff[i], lane_div[i]);
   end

   // Item capture, mix, scale and output registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_data;
      end
      if (cmd.ramp) begin
         stop_ff <= req_ff.mode;
      end
      if (cmd.mix) begin
         for (int i = 0; i < 4; i++) sum_ff[i] <= sum_in[i];
      end
      if (cmd.scale) begin
         for (int i = 0; i < 4; i++) begin
            mag_ff[i] <= stop_ff ? 7'd0 : lane_res[i][6:0];
            neg_ff[i] <= lane_res[i][7];
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Duty and direction of each motor.
   always_comb begin
      rsp_in.motor1_duty = duty_of(mag_ff[0]);
      rsp_in.motor1_dir  = dir_of(mag_ff[0], neg_ff[0]);
      rsp_in.motor2_duty = duty_of(mag_ff[1]);
      rsp_in.motor2_dir  = dir_of(mag_ff[1], neg_ff[1]);
      rsp_in.motor3_duty = duty_of(mag_ff[2]);
      rsp_in.motor3_dir  = dir_of(mag_ff[2], neg_ff[2]);
      rsp_in.motor4_duty = duty_of(mag_ff[3]);
      rsp_in.motor4_dir  = dir_of(mag_ff[3], neg_ff[3]);
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/ramped_holonomic_motor_mixer.sv
// Top level of the ramped holonomic motor mixer.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    req_data: mode and three axis commands
//  rsp      out        rsp_valid/rsp_ready    rsp_data: duty and direction of four motors
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each item passes through capture, ramp update, mixing multiply and scaling multiply
// before its result is loaded into the output register.
// A new item is accepted in the cycle after the result is loaded, while it still waits.
// Reset is synchronous and clears the ramps, the configuration registers and the handshake state.
// A stalled result holds the controller in its last step until the output is free.
module ramped_holonomic_motor_mixer #(
   parameter int FRACTION_BITS = rhmm_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rhmm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rhmm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [14:0]      csr_data
);
   import rhmm_pkg::*;

   cmd_type cmd;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   rhmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   rhmm_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/rhmm_checker.sv
// Port-level checker for the motor mixer, with its bind statement.
module rhmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rhmm_pkg::rsp_type rsp_data
);
   import rhmm_pkg::*;

   // A waiting result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An accepted item keeps the input closed for the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after an item");

   // A motor is off exactly when its duty is zero.
   a_off_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.motor1_dir == DIR_OFF) == (rsp_data.motor1_duty == 8'd0))
                 && ((rsp_data.motor2_dir == DIR_OFF) == (rsp_data.motor2_duty == 8'd0))
                 && ((rsp_data.motor3_dir == DIR_OFF) == (rsp_data.motor3_duty == 8'd0))
                 && ((rsp_data.motor4_dir == DIR_OFF) == (rsp_data.motor4_duty == 8'd0)))
      else $error("motor direction and duty disagree");

   // A result only appears when an item was in progress in the cycle before.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared with no item in progress");

endmodule

bind ramped_holonomic_motor_mixer rhmm_checker u_rhmm_checker (.*);

>>> dv/ramped_holonomic_motor_mixer_test.sv
// Self-checking testbench for the ramped holonomic motor mixer: random and directed items.
module ramped_holonomic_motor_mixer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rhmm_pkg::*;

   localparam int FB = FRACTION_BITS_DEF;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_DRIVE_KIND;
   logic [14:0] csr_data = '0;

   ramped_holonomic_motor_mixer dut (.*);

   always #5 clock = ~clock;

   // Predictor state and configuration.
   logic [1:0] kind_q = KIND_DIFF;
   int trim_q = 0;
   int step_q = 1280;
   longint rx = 0, ry = 0, rw = 0;

   req_type pending_cmds[$];
   rsp_type expected_outputs[$];
   int errors = 0;
   bit stim_done = 0;
   longint cycles = 0;

   // Command scaled to a ramp target, truncated toward zero.
   function automatic longint axis_goal(logic signed [15:0] c);
      longint v, m;
      v = c;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      m = v < 0 ? -v : v;
      m = ((m * 100) << FB) >> 14;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint ramp_toward(longint cur, longint goal);
      longint v;
      v = cur;
      if (v < goal) v += step_q;
      else if (v > goal) v -= step_q;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v;
   endfunction

   function automatic void motor_drive(longint s, output logic [7:0] duty,
                                       output logic [1:0] dir);
      longint m;
      if (s > 100) s = 100;
      if (s < -100) s = -100;
      m = s < 0 ? -s : s;
      duty = 8'(m * 255 / 100);
      dir = s > 0 ? DIR_FWD : (s < 0 ? DIR_REV : DIR_OFF);
   endfunction

   // Works out the motor outputs for one item and advances the ramps.
   function automatic rsp_type mix_motors(req_type r);
      rsp_type o;
      longint one, d, lf, rf, l, rr;
      one = longint'(1) << FB;
      o = '0;
      if (r.mode) begin
         rx = 0; ry = 0; rw = 0;
         return o;
      end
      rx = ramp_toward(rx, axis_goal(r.strafe_cmd));
      ry = ramp_toward(ry, axis_goal(r.forward_cmd));
      rw = ramp_toward(rw, axis_goal(r.turn_cmd));
      case (kind_q)
         KIND_DIFF: begin
            d = trim_q < 0 ? -trim_q : trim_q;
            if (d > 200) d = 200;
            lf = 200; rf = 200;
            if (trim_q < 0) rf = 200 - d;
            else if (trim_q > 0) lf = 200 - d;
            rx = 0;
            l = ((ry - rw) * lf) / (200 * one);
            rr = ((ry + rw) * rf) / (200 * one);
            motor_drive(l, o.motor1_duty, o.motor1_dir);
            motor_drive(l, o.motor3_duty, o.motor3_dir);
            motor_drive(rr, o.motor2_duty, o.motor2_dir);
            motor_drive(rr, o.motor4_duty, o.motor4_dir);
         end
         KIND_OMNI: begin
            motor_drive((ry + rw) / one, o.motor1_duty, o.motor1_dir);
            motor_drive((-500 * ry + 866 * rx + 1000 * rw) / (1000 * one),
                        o.motor2_duty, o.motor2_dir);
            motor_drive((-500 * ry - 866 * rx + 1000 * rw) / (1000 * one),
                        o.motor3_duty, o.motor3_dir);
         end
         KIND_MECAN: begin
            motor_drive((ry + rx + rw) / one, o.motor1_duty, o.motor1_dir);
            motor_drive((ry - rx - rw) / one, o.motor2_duty, o.motor2_dir);
            motor_drive((ry - rx + rw) / one, o.motor3_duty, o.motor3_dir);
            motor_drive((ry + rx - rw) / one, o.motor4_duty, o.motor4_dir);
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Driver: presents queued items, with random gaps between them.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(mix_motors(req_data));
            send_gap = idle_gap();
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_data <= pending_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result with the oldest expectation; random stalls.
   int stall = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               e = expected_outputs.pop_front();
               if (rsp_data.motor1_duty !== e.motor1_duty) begin
                  $error("motor1_duty exp %0d got %0d", e.motor1_duty, rsp_data.motor1_duty);
                  errors++;
               end
               if (rsp_data.motor1_dir !== e.motor1_dir) begin
                  $error("motor1_dir exp %0d got %0d", e.motor1_dir, rsp_data.motor1_dir);
                  errors++;
               end
               if (rsp_data.motor2_duty !== e.motor2_duty) begin
                  $error("motor2_duty exp %0d got %0d", e.motor2_duty, rsp_data.motor2_duty);
                  errors++;
               end
               if (rsp_data.motor2_dir !== e.motor2_dir) begin
                  $error("motor2_dir exp %0d got %0d", e.motor2_dir, rsp_data.motor2_dir);
                  errors++;
               end
               if (rsp_data.motor3_duty !== e.motor3_duty) begin
                  $error("motor3_duty exp %0d got %0d", e.motor3_duty, rsp_data.motor3_duty);
                  errors++;
               end
               if (rsp_data.motor3_dir !== e.motor3_dir) begin
                  $error("motor3_dir exp %0d got %0d", e.motor3_dir, rsp_data.motor3_dir);
                  errors++;
               end
               if (rsp_data.motor4_duty !== e.motor4_duty) begin
                  $error("motor4_duty exp %0d got %0d", e.motor4_duty, rsp_data.motor4_duty);
                  errors++;
               end
               if (rsp_data.motor4_dir !== e.motor4_dir) begin
                  $error("motor4_dir exp %0d got %0d", e.motor4_dir, rsp_data.motor4_dir);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall = idle_gap();
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ramped_holonomic_motor_mixer_test NOT OK");
         $finish;
      end
   end

   // Writes one register, holding valid until it is taken, then idles with valid low.
   task automatic write_reg(logic [1:0] idx, logic [14:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DRIVE_KIND: kind_q = val[1:0];
         CSR_SIDE_TRIM: trim_q = $signed(val[8:0]);
         CSR_RAMP_STEP: step_q = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Waits until every item has been taken and answered, then lets the pipe drain.
   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_outputs.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic signed [15:0] axis_value();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd16384;
         3: return -16'sd16384;
         4: return 16'($urandom_range(0, 65535));
         default: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
      endcase
   endfunction

   function automatic req_type rand_cmd();
      req_type r;
      r.mode = ($urandom_range(0, 19) == 0);
      r.strafe_cmd = axis_value();
      r.forward_cmd = axis_value();
      r.turn_cmd = axis_value();
      return r;
   endfunction

   function automatic req_type mk(logic m, int x, int y, int w);
      req_type r;
      r.mode = m;
      r.strafe_cmd = 16'(x);
      r.forward_cmd = 16'(y);
      r.turn_cmd = 16'(w);
      return r;
   endfunction

   // Each phase: kind, trim, step.
   int kinds[8] = '{0, 0, 0, 1, 2, 3, 2, 1};
   int trims[8] = '{0, -200, 200, 0, -7, 255, 0, 100};
   int steps[8] = '{1280, 25600, 1, 0, 32767, 5000, 300, 25600};

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, stop, both directions in the differential and omni kinds.
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_DRIVE_KIND, 15'(kinds[ph]));
         write_reg(CSR_SIDE_TRIM, 15'(trims[ph]) & 15'h1ff);
         write_reg(CSR_RAMP_STEP, 15'(steps[ph]));
         pending_cmds.push_back(mk(0, 32767, 32767, 32767));
         pending_cmds.push_back(mk(0, 32767, 32767, -32768));
         pending_cmds.push_back(mk(0, -32768, -32768, 32767));
         pending_cmds.push_back(mk(0, 0, 16384, 0));
         pending_cmds.push_back(mk(1, 32767, 32767, 32767));
         pending_cmds.push_back(mk(0, 1, -1, 0));
         drain();
      end
      // Random phases over all settings, including random ones.
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < 8) begin
            write_reg(CSR_DRIVE_KIND, 15'(kinds[ph]));
            write_reg(CSR_SIDE_TRIM, 15'(trims[ph]) & 15'h1ff);
            write_reg(CSR_RAMP_STEP, 15'(steps[ph]));
         end else begin
            write_reg(CSR_DRIVE_KIND, 15'($urandom_range(0, 3)));
            write_reg(CSR_SIDE_TRIM, 15'($urandom_range(0, 511)));
            write_reg(CSR_RAMP_STEP, 15'($urandom_range(0, 32767)));
         end
         for (int i = 0; i < 93; i++) pending_cmds.push_back(rand_cmd());
         drain();
      end
      stim_done = 1;
      if (errors == 0) begin
         $display("ramped_holonomic_motor_mixer_test OK");
      end else begin
         $display("ramped_holonomic_motor_mixer_test NOT OK");
      end
      $finish;
   end
endmodule

>>> ramped_holonomic_motor_mixer.f
rtl/rhmm_pkg.sv
rtl/rhmm_ctrl.sv
rtl/rhmm_datapath.sv
rtl/ramped_holonomic_motor_mixer.sv
rtl/rhmm_checker.sv
dv/ramped_holonomic_motor_mixer_test.sv
